// ===== hw/rtl/cpc_pkg.sv =====
`default_nettype none

package cpc_pkg;

  localparam int unsigned InDepth  = 512;
  localparam int unsigned ResDepth = 256;
  localparam int unsigned InAw     = $clog2(InDepth);
  localparam int unsigned ResAw    = $clog2(ResDepth);
  localparam int unsigned WpW      = 10;
  localparam int unsigned DivNw    = 25;
  localparam int unsigned DivDw    = 9;
  localparam int unsigned DivCw    = $clog2(DivNw);

  localparam logic [31:0] UnitStep = 32'h0001_0000;

  localparam logic [7:0] CMD_PLANAR  = 8'h01;
  localparam logic [7:0] CMD_TRANSP  = 8'h03;
  localparam logic [7:0] CMD_OVERLAY = 8'h05;
  localparam logic [7:0] CMD_REVERSE = 8'h06;
  localparam logic [7:0] CMD_MUL     = 8'h09;
  localparam logic [7:0] CMD_SCALE   = 8'h0d;

  typedef enum logic [1:0] {
    STG_CMD,
    STG_FIX,
    STG_BMP
  } stage_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_DIV,
    S_ADDR,
    S_DATA,
    S_MULW
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/cpc_div.sv =====
`default_nettype none

module cpc_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [cpc_pkg::DivNw-1:0]  dividend_i,
  input  wire logic [cpc_pkg::DivDw-1:0]  divisor_i,
  output logic                            done_o,
  output logic [cpc_pkg::DivNw-1:0]       quot_o
);

  logic                       run_q;
  logic                       done_q;
  logic [cpc_pkg::DivCw-1:0]  cnt_q;
  logic [cpc_pkg::DivDw-1:0]  div_q;
  logic [cpc_pkg::DivDw-1:0]  rem_q;
  logic [cpc_pkg::DivDw-1:0]  rem_d;
  logic [cpc_pkg::DivNw-1:0]  quo_q;
  logic [cpc_pkg::DivDw:0]    trial;
  logic                       ge;

  always_comb begin
    trial = {rem_q, quo_q[cpc_pkg::DivNw-1]};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? cpc_pkg::DivDw'(trial - {1'b0, div_q}) : cpc_pkg::DivDw'(trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == '0);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= cpc_pkg::DivCw'(cpc_pkg::DivNw - 1);
      end else if (run_q) begin
        if (cnt_q == '0) begin
          run_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[cpc_pkg::DivNw-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_coprocessor_command_port.sv =====
// Byte-wide command port of a bitmap coprocessor.
// A request is taken when start is high and busy is low. opcode_i = 1 writes
// write_byte_i to the data port; opcode_i = 0 reads one result byte.
// The first write of a command is the command byte, then its parameter bytes
// and, for some commands, a run of bitmap bytes. Other writes leave busy low;
// the write that completes a command runs it on one shared datapath, which
// keeps busy high until the command ends and, but for a multiply, reads the
// input memory one byte per pass through the address and data states;
// scaling to fewer bytes first waits for the serial divider. Setting the
// transparent color, a scale to zero bytes or an unknown command keeps busy
// low. A read raises busy in the cycle after it is taken, and in that cycle
// valid_o is high with read_byte_o, which is 0xFF when no result is left.
// The receiver cannot stall. Reset clears all control state, awaits a command
// byte and holds no results; the input memory is tracked by a fill count and
// needs no clearing pass.
`default_nettype none

module bitmap_coprocessor_command_port (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       opcode_i,
  input  wire logic [7:0] write_byte_i,
  output logic            valid_o,
  output logic [7:0]      read_byte_o
);

  cpc_pkg::state_e state_q, state_d;
  cpc_pkg::stage_e stage_q;

  logic [7:0]               cmd_q;
  logic [3:0]               tc_q;
  logic [7:0]               n_q;
  logic [7:0]               t_q;
  logic [cpc_pkg::WpW-1:0]  exp_q;
  logic [cpc_pkg::WpW-1:0]  wp_q;
  logic [cpc_pkg::WpW-1:0]  hwm_q;
  logic [7:0]               rcnt_q;
  logic [7:0]               rpos_q;
  logic [7:0]               p_q [4];
  logic [7:0]               lim_q;
  logic [7:0]               i_q;
  logic [1:0]               j_q;
  logic [7:0]               acc_q;
  logic [7:0]               bg_q;
  logic [31:0]              pos_q;
  logic [31:0]              step_q;
  logic [31:0]              prod_q;
  logic                     hit_q;
  logic [7:0]               rres_q;
  logic [7:0]               rdata_q;
  logic                     rok_q;

  logic [7:0] imem [cpc_pkg::InDepth];
  logic [7:0] rmem [cpc_pkg::ResDepth];

  logic                     acc_w, acc_r;
  logic [cpc_pkg::WpW-1:0]  wpn;
  logic                     complete, param_cmd, enter_bmp, exec_go;
  logic [7:0]               new_s, new_t;
  logic [cpc_pkg::WpW-1:0]  cnt;
  logic [cpc_pkg::InAw-1:0] raddr;
  logic                     rin;
  logic [7:0]               byte_v;
  logic [1:0]               plane;
  logic [7:0]               acc_n;
  logic [3:0]               pix;
  logic [3:0]               hi_n, lo_n;
  logic                     res_we;
  logic [cpc_pkg::ResAw-1:0] res_wa;
  logic [7:0]               res_wd;
  logic                     div_go, div_done;
  logic [cpc_pkg::DivNw-1:0] div_q;
  logic [cpc_pkg::DivDw-1:0] divisor;

  assign acc_w = start && !busy && opcode_i;
  assign acc_r = start && !busy && !opcode_i;

  always_comb begin
    wpn       = wp_q + 1'b1;
    complete  = acc_w && (stage_q != cpc_pkg::STG_CMD) && (wpn == exp_q);
    param_cmd = (cmd_q == cpc_pkg::CMD_OVERLAY) || (cmd_q == cpc_pkg::CMD_REVERSE) ||
                (cmd_q == cpc_pkg::CMD_SCALE);
    enter_bmp = complete && (stage_q != cpc_pkg::STG_BMP) && param_cmd;
    new_s     = n_q;
    new_t     = t_q;
    cnt       = '0;
    if (enter_bmp) begin
      case (cmd_q)
        cpc_pkg::CMD_OVERLAY: begin
          new_s = write_byte_i;
          cnt   = {1'b0, write_byte_i, 1'b0};
        end
        cpc_pkg::CMD_REVERSE: begin
          new_s = write_byte_i;
          cnt   = {2'b0, write_byte_i};
        end
        default: begin
          new_s = p_q[0];
          new_t = write_byte_i;
          cnt   = cpc_pkg::WpW'(({1'b0, p_q[0]} + 9'd1) >> 1);
        end
      endcase
    end
    exec_go = complete && (!enter_bmp || (cnt == '0));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cpc_pkg::S_IDLE: begin
        if (acc_r) begin
          state_d = cpc_pkg::S_RESP;
        end else if (exec_go) begin
          case (cmd_q)
            cpc_pkg::CMD_PLANAR, cpc_pkg::CMD_OVERLAY, cpc_pkg::CMD_REVERSE:
              state_d = cpc_pkg::S_ADDR;
            cpc_pkg::CMD_MUL: state_d = cpc_pkg::S_MULW;
            cpc_pkg::CMD_SCALE: begin
              if (new_t == 8'd0) begin
                state_d = cpc_pkg::S_IDLE;
              end else if (new_s <= new_t) begin
                state_d = cpc_pkg::S_ADDR;
              end else begin
                state_d = cpc_pkg::S_DIV;
              end
            end
            default: state_d = cpc_pkg::S_IDLE;
          endcase
        end
      end
      cpc_pkg::S_RESP: state_d = cpc_pkg::S_IDLE;
      cpc_pkg::S_DIV: begin
        if (div_done) begin
          state_d = cpc_pkg::S_ADDR;
        end
      end
      cpc_pkg::S_ADDR: state_d = (i_q == lim_q) ? cpc_pkg::S_IDLE : cpc_pkg::S_DATA;
      cpc_pkg::S_DATA: state_d = cpc_pkg::S_ADDR;
      cpc_pkg::S_MULW: begin
        if (j_q == 2'd3) begin
          state_d = cpc_pkg::S_IDLE;
        end
      end
      default: state_d = cpc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy    = (state_q != cpc_pkg::S_IDLE);
    valid_o = (state_q == cpc_pkg::S_RESP);
    div_go  = (state_q == cpc_pkg::S_IDLE) && !acc_r && exec_go &&
              (cmd_q == cpc_pkg::CMD_SCALE) && (new_t != 8'd0) && (new_s > new_t);
  end

  assign read_byte_o = hit_q ? rres_q : 8'hff;
  assign divisor     = {new_t, 1'b1};

  cpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i ({new_s, 17'd0}),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  always_comb begin
    raddr = '0;
    rin   = 1'b1;
    case (cmd_q)
      cpc_pkg::CMD_PLANAR: raddr = cpc_pkg::InAw'({i_q[3:1], j_q});
      cpc_pkg::CMD_OVERLAY: begin
        raddr = j_q[0] ? cpc_pkg::InAw'({1'b0, n_q} + {1'b0, i_q}) : cpc_pkg::InAw'(i_q);
      end
      cpc_pkg::CMD_SCALE: begin
        raddr = pos_q[25:17];
        rin   = (pos_q[31:26] == '0);
      end
      default: raddr = cpc_pkg::InAw'(i_q);
    endcase
  end

  always_comb begin
    byte_v = rok_q ? rdata_q : 8'd0;
    plane  = {i_q[4], i_q[0]};
    acc_n  = acc_q | ({byte_v[3'd4 + {1'b0, plane}], byte_v[{1'b0, plane}], 6'd0} >>
                      {j_q, 1'b0});
    pix    = pos_q[16] ? byte_v[3:0] : byte_v[7:4];
    hi_n   = (byte_v[7:4] == tc_q) ? bg_q[7:4] : byte_v[7:4];
    lo_n   = (byte_v[3:0] == tc_q) ? bg_q[3:0] : byte_v[3:0];
    res_we = 1'b0;
    res_wa = i_q;
    res_wd = '0;
    if (state_q == cpc_pkg::S_MULW) begin
      res_we = 1'b1;
      res_wa = cpc_pkg::ResAw'(j_q);
      res_wd = 8'(prod_q >> {j_q, 3'd0});
    end else if (state_q == cpc_pkg::S_DATA) begin
      case (cmd_q)
        cpc_pkg::CMD_PLANAR: begin
          res_we = (j_q == 2'd3);
          res_wd = acc_n;
        end
        cpc_pkg::CMD_OVERLAY: begin
          res_we = j_q[0];
          res_wd = {hi_n, lo_n};
        end
        cpc_pkg::CMD_REVERSE: begin
          res_we = 1'b1;
          res_wa = n_q - 8'd1 - i_q;
          res_wd = {byte_v[3:0], byte_v[7:4]};
        end
        default: begin
          res_we = j_q[0];
          res_wd = acc_q | {4'd0, pix};
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_w && (stage_q != cpc_pkg::STG_CMD) && !wp_q[cpc_pkg::WpW-1]) begin
      imem[wp_q[cpc_pkg::InAw-1:0]] <= write_byte_i;
    end
    if (state_q == cpc_pkg::S_ADDR) begin
      rdata_q <= imem[raddr];
      rok_q   <= rin && ({1'b0, raddr} < hwm_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      rmem[res_wa] <= res_wd;
    end
    if (acc_r) begin
      rres_q <= rmem[rpos_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpc_pkg::S_IDLE;
      stage_q <= cpc_pkg::STG_CMD;
      cmd_q   <= '0;
      tc_q    <= '0;
      n_q     <= '0;
      t_q     <= '0;
      exp_q   <= '0;
      wp_q    <= '0;
      hwm_q   <= '0;
      rcnt_q  <= '0;
      rpos_q  <= '0;
      lim_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (acc_r) begin
        hit_q <= (rpos_q < rcnt_q);
        if (rpos_q < rcnt_q) begin
          if (rpos_q + 8'd1 == rcnt_q) begin
            rpos_q <= '0;
            rcnt_q <= '0;
          end else begin
            rpos_q <= rpos_q + 8'd1;
          end
        end
      end
      if (acc_w) begin
        if (stage_q == cpc_pkg::STG_CMD) begin
          cmd_q  <= write_byte_i;
          hwm_q  <= '0;
          wp_q   <= '0;
          rpos_q <= '0;
          rcnt_q <= '0;
          stage_q <= cpc_pkg::STG_FIX;
          case (write_byte_i)
            cpc_pkg::CMD_PLANAR: exp_q <= cpc_pkg::WpW'(32);
            cpc_pkg::CMD_TRANSP, cpc_pkg::CMD_OVERLAY, cpc_pkg::CMD_REVERSE:
              exp_q <= cpc_pkg::WpW'(1);
            cpc_pkg::CMD_MUL: exp_q <= cpc_pkg::WpW'(4);
            cpc_pkg::CMD_SCALE: exp_q <= cpc_pkg::WpW'(2);
            default: begin
              exp_q   <= '0;
              stage_q <= cpc_pkg::STG_CMD;
            end
          endcase
        end else begin
          if (!wp_q[cpc_pkg::WpW-1] && (wpn > hwm_q)) begin
            hwm_q <= wpn;
          end
          wp_q <= wpn;
          if (enter_bmp) begin
            n_q     <= new_s;
            t_q     <= new_t;
            wp_q    <= '0;
            exp_q   <= cnt;
            stage_q <= cpc_pkg::STG_BMP;
          end
          if (exec_go) begin
            stage_q <= cpc_pkg::STG_CMD;
            exp_q   <= '0;
            wp_q    <= '0;
            rpos_q  <= '0;
            rcnt_q  <= '0;
            i_q     <= '0;
            j_q     <= '0;
            case (cmd_q)
              cpc_pkg::CMD_PLANAR: lim_q <= 8'd32;
              cpc_pkg::CMD_SCALE:  lim_q <= new_t;
              default:             lim_q <= new_s;
            endcase
            if (cmd_q == cpc_pkg::CMD_TRANSP) begin
              tc_q <= write_byte_i[3:0];
            end
          end
        end
      end
      case (state_q)
        cpc_pkg::S_ADDR: begin
          if (i_q == lim_q) begin
            rcnt_q <= lim_q;
          end
        end
        cpc_pkg::S_DATA: begin
          case (cmd_q)
            cpc_pkg::CMD_PLANAR: begin
              j_q <= j_q + 2'd1;
              if (j_q == 2'd3) begin
                i_q <= i_q + 8'd1;
              end
            end
            cpc_pkg::CMD_REVERSE: i_q <= i_q + 8'd1;
            default: begin
              j_q <= {1'b0, !j_q[0]};
              if (j_q[0]) begin
                i_q <= i_q + 8'd1;
              end
            end
          endcase
        end
        cpc_pkg::S_MULW: begin
          j_q <= j_q + 2'd1;
          if (j_q == 2'd3) begin
            rcnt_q <= 8'd4;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_w && (stage_q != cpc_pkg::STG_CMD) && (stage_q != cpc_pkg::STG_BMP) &&
        (wp_q < cpc_pkg::WpW'(4))) begin
      p_q[wp_q[1:0]] <= write_byte_i;
    end
    if (exec_go) begin
      acc_q  <= '0;
      pos_q  <= '0;
      step_q <= cpc_pkg::UnitStep;
      prod_q <= {16'd0, p_q[1], p_q[0]} * {16'd0, write_byte_i, p_q[2]};
    end
    if (div_done) begin
      step_q <= 32'(div_q);
    end
    if (state_q == cpc_pkg::S_DATA) begin
      case (cmd_q)
        cpc_pkg::CMD_PLANAR: acc_q <= (j_q == 2'd3) ? 8'd0 : acc_n;
        cpc_pkg::CMD_OVERLAY: begin
          if (!j_q[0]) begin
            bg_q <= byte_v;
          end
        end
        cpc_pkg::CMD_SCALE: begin
          pos_q <= pos_q + step_q;
          acc_q <= j_q[0] ? 8'd0 : {pix, 4'd0};
        end
        default: ;
      endcase
    end
  end

  a_valid_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy)
    else $error("result strobe outside a busy cycle");

  a_read_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !opcode_i) |=> valid_o)
    else $error("read request not answered in the next cycle");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_read_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rcnt_q == 8'd0) |-> (rpos_q == 8'd0))
    else $error("read position set with no results held");

endmodule

`default_nettype wire
